// ===== rtl/tecavg_pkg.sv =====
package tecavg_pkg;

   // Detection time fields and the packed time code.
   localparam int HOUR_BITS        = 5;
   localparam int MINUTE_BITS      = 6;
   localparam int SECOND_BITS      = 6;
   localparam int TIME_FIELDS_BITS = HOUR_BITS + MINUTE_BITS + SECOND_BITS;
   localparam int TIME_BITS        = 18;
   localparam int TIME_CALC_BITS   = TIME_BITS + 1;
   localparam int HOUR_SCALE       = 10000;
   localparam int MINUTE_SCALE     = 100;

   // Configuration register widths, indexes and reset values.
   localparam int WINDOW_BITS     = 8;
   localparam int LIMIT_BITS      = 10;
   localparam int CAMERA_BITS     = 4;
   localparam int CSR_DATA_BITS   = 10;
   localparam int CSR_ADDR_BITS   = 2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_TIME_WINDOW     = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DISTANCE_LIMIT  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_VALID_COORD = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CAMERA_ID       = 2'd3;

   localparam logic [WINDOW_BITS-1:0] TIME_WINDOW_RESET     = 8'd3;
   localparam logic [LIMIT_BITS-1:0]  DISTANCE_LIMIT_RESET  = 10'd50;
   localparam logic [LIMIT_BITS-1:0]  MIN_VALID_COORD_RESET = 10'd10;
   localparam logic [CAMERA_BITS-1:0] CAMERA_ID_RESET       = 4'd1;

   // Item sequencer of the top level.
   typedef enum logic [8:0] {
      ST_IDLE        = 9'b000000001,
      ST_EVAL        = 9'b000000010,
      ST_DECIDE      = 9'b000000100,
      ST_EMIT_OLD    = 9'b000001000,
      ST_BLEND_TIME  = 9'b000010000,
      ST_BLEND_X     = 9'b000100000,
      ST_BLEND_Y     = 9'b001000000,
      ST_FLUSH_CHECK = 9'b010000000,
      ST_EMIT_FLUSH  = 9'b100000000
   } seq_state_type;

   // Serial multiply-then-divide unit.
   typedef enum logic [3:0] {
      BL_IDLE = 4'b0001,
      BL_MUL  = 4'b0010,
      BL_ADD  = 4'b0100,
      BL_DIV  = 4'b1000
   } blend_state_type;

endpackage

// ===== rtl/tecavg_blend.sv =====
// Serial weighted average: (old * (n - 1) + neu) / n, truncated.
// Shift-add multiply one multiplier bit a cycle, one add of neu, then a
// restoring division one quotient bit a cycle in the same register.
module tecavg_blend #(
   parameter int VAL_BITS = 18,
   parameter int CNT_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VAL_BITS-1:0] old_val,
   input  logic [VAL_BITS-1:0] neu_val,
   input  logic [CNT_BITS-1:0] count,
   output logic                done,
   output logic [VAL_BITS-1:0] result
);
   import tecavg_pkg::*;

   localparam int ACC_BITS  = VAL_BITS + CNT_BITS;
   localparam int STEP_MAX  = ((VAL_BITS > CNT_BITS) ? VAL_BITS : CNT_BITS) - 1;
   localparam int STEP_BITS = (STEP_MAX > 0) ? $clog2(STEP_MAX + 1) : 1;

   blend_state_type        state_ff, state_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [CNT_BITS-1:0]    mult_ff, mult_in;
   logic [CNT_BITS-1:0]    div_ff, div_in;
   logic [VAL_BITS-1:0]    old_ff, old_in;
   logic [VAL_BITS-1:0]    neu_ff, neu_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   done_ff, done_in;

   logic [VAL_BITS:0]      mul_sum;
   logic [CNT_BITS:0]      partial;
   logic                   fits;
   logic [CNT_BITS:0]      reduced;
   logic [CNT_BITS-1:0]    rem_next;

   // Add the multiplicand into the upper half when the multiplier bit is set.
   assign mul_sum = {1'b0, acc_ff[ACC_BITS-1:CNT_BITS]}
                  + (mult_ff[0] ? {1'b0, old_ff} : '0);

   // Bring down the next dividend bit and try the subtraction.
   assign partial  = {acc_ff[ACC_BITS-1:VAL_BITS], acc_ff[VAL_BITS-1]};
   assign fits     = partial >= {1'b0, div_ff};
   assign reduced  = partial - {1'b0, div_ff};
   assign rem_next = fits ? reduced[CNT_BITS-1:0] : partial[CNT_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      mult_in  = mult_ff;
      div_in   = div_ff;
      old_in   = old_ff;
      neu_in   = neu_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (state_ff)
         BL_IDLE: begin
            if (start) begin
               old_in   = old_val;
               neu_in   = neu_val;
               div_in   = count;
               mult_in  = count - CNT_BITS'(1);
               acc_in   = '0;
               step_in  = STEP_BITS'(CNT_BITS - 1);
               state_in = BL_MUL;
            end
         end
         BL_MUL: begin
            acc_in  = {mul_sum, acc_ff[CNT_BITS-1:1]};
            mult_in = mult_ff >> 1;
            if (step_ff == '0) begin
               state_in = BL_ADD;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         BL_ADD: begin
            acc_in   = acc_ff + ACC_BITS'(neu_ff);
            step_in  = STEP_BITS'(VAL_BITS - 1);
            state_in = BL_DIV;
         end
         BL_DIV: begin
            acc_in = {rem_next, acc_ff[VAL_BITS-2:0], fits};
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = BL_IDLE;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         default: begin
            state_in = BL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff  <= acc_in;
      mult_ff <= mult_in;
      div_ff  <= div_in;
      old_ff  <= old_in;
      neu_ff  <= neu_in;
      step_ff <= step_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[VAL_BITS-1:0];

endmodule

// ===== rtl/touch_event_cluster_averager.sv =====
// Channel  | Direction | Beat contents (tdata from bit 0 up)            | tlast
// ---------+-----------+------------------------------------------------+--------------
// req_     | in        | hours, minutes, seconds, point_x, point_y      | end_of_stream
// rsp_     | out       | cluster_time, cluster_x, cluster_y, camera     | last_of_run
// csr_     | in        | write only: csr_addr selects, csr_wdata holds  | -
//
// One detection is in flight at a time: req_tready is low while the sequencer starts,
// drops, merges or emits it. A merge runs three serial blends (time, x, y) on one shared
// unit. rsp_ has one output register: accept the next detection while a finished cluster
// waits; hold the sequencer only when a further result is due first. Reset is synchronous,
// restores the configuration and control registers and empties the held cluster.
module touch_event_cluster_averager #(
   parameter int MAX_COUNT  = 255,
   parameter int COORD_BITS = 10
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // hours, minutes, seconds, point_x, point_y, zero fill
   input  logic [((tecavg_pkg::TIME_FIELDS_BITS + 2*COORD_BITS + 7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // cluster_time, cluster_x, cluster_y, camera, zero fill
   output logic [((tecavg_pkg::TIME_BITS + 2*COORD_BITS + tecavg_pkg::CAMERA_BITS
                  + 7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast,

   input  logic                                  csr_we,
   input  logic [tecavg_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [tecavg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tecavg_pkg::*;

   localparam int CNT_BITS  = $clog2(MAX_COUNT + 1);
   localparam int GAP_BITS  = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;
   localparam int RSP_BITS  = ((TIME_BITS + 2*COORD_BITS + CAMERA_BITS + 7)/8)*8;
   localparam int X_LSB     = TIME_FIELDS_BITS;
   localparam int Y_LSB     = TIME_FIELDS_BITS + COORD_BITS;

   // Configuration.
   logic [WINDOW_BITS-1:0]  time_window_ff;
   logic [LIMIT_BITS-1:0]   distance_limit_ff;
   logic [LIMIT_BITS-1:0]   min_valid_ff;
   logic [CAMERA_BITS-1:0]  camera_id_ff;

   // Sequencer and held cluster.
   seq_state_type           state_ff, state_in;
   logic                    held_valid_ff, held_valid_in;
   logic [TIME_BITS-1:0]    held_time_ff, held_time_in;
   logic [COORD_BITS-1:0]   held_x_ff, held_x_in;
   logic [COORD_BITS-1:0]   held_y_ff, held_y_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [TIME_BITS-1:0]    last_time_ff, last_time_in;

   // Accepted detection.
   logic [TIME_BITS-1:0]    det_time_ff, det_time_in;
   logic [COORD_BITS-1:0]   det_x_ff, det_x_in;
   logic [COORD_BITS-1:0]   det_y_ff, det_y_in;
   logic                    det_eos_ff, det_eos_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TIME_BITS-1:0]    rsp_time_ff, rsp_time_in;
   logic [COORD_BITS-1:0]   rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]   rsp_y_ff, rsp_y_in;
   logic [CAMERA_BITS-1:0]  rsp_camera_ff, rsp_camera_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Blend unit hookup.
   logic                    blend_start;
   logic [TIME_BITS-1:0]    blend_old;
   logic [TIME_BITS-1:0]    blend_neu;
   logic [CNT_BITS-1:0]     blend_count;
   logic                    blend_done;
   logic [TIME_BITS-1:0]    blend_result;

   logic [HOUR_BITS-1:0]      req_hours;
   logic [MINUTE_BITS-1:0]    req_minutes;
   logic [SECOND_BITS-1:0]    req_seconds;
   logic [TIME_CALC_BITS-1:0] time_sum;
   logic [TIME_BITS-1:0]      time_sat;

   logic signed [TIME_BITS:0] time_diff;
   logic signed [TIME_BITS:0] window_ext;
   logic                      in_window;
   logic [COORD_BITS-1:0]     gap_x;
   logic [COORD_BITS-1:0]     gap_y;
   logic                      near;
   logic                      held_low;
   logic [CNT_BITS:0]         count_inc;
   logic [CNT_BITS-1:0]       count_sat;
   logic                      rsp_free;

   // Build the time code at the input and clamp it to the code width.
   assign req_hours   = req_tdata[HOUR_BITS-1:0];
   assign req_minutes = req_tdata[HOUR_BITS +: MINUTE_BITS];
   assign req_seconds = req_tdata[HOUR_BITS + MINUTE_BITS +: SECOND_BITS];
   assign time_sum    = TIME_CALC_BITS'(req_hours) * TIME_CALC_BITS'(HOUR_SCALE)
                      + TIME_CALC_BITS'(req_minutes) * TIME_CALC_BITS'(MINUTE_SCALE)
                      + TIME_CALC_BITS'(req_seconds);
   assign time_sat    = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];

   // Decisions against the held cluster (after any replacement).
   assign time_diff  = $signed({1'b0, det_time_ff}) - $signed({1'b0, held_time_ff});
   assign window_ext = $signed((TIME_BITS + 1)'(time_window_ff));
   assign in_window  = time_diff < window_ext;
   assign gap_x      = (held_x_ff > det_x_ff) ? held_x_ff - det_x_ff : det_x_ff - held_x_ff;
   assign gap_y      = (held_y_ff > det_y_ff) ? held_y_ff - det_y_ff : det_y_ff - held_y_ff;
   assign near       = (GAP_BITS'(gap_x) < GAP_BITS'(distance_limit_ff))
                    || (GAP_BITS'(gap_y) < GAP_BITS'(distance_limit_ff));
   assign held_low   = (GAP_BITS'(held_x_ff) < GAP_BITS'(min_valid_ff))
                    || (GAP_BITS'(held_y_ff) < GAP_BITS'(min_valid_ff));

   // Saturating merge count.
   assign count_inc = {1'b0, count_ff} + (CNT_BITS + 1)'(1);
   assign count_sat = (count_inc > (CNT_BITS + 1)'(MAX_COUNT)) ? CNT_BITS'(MAX_COUNT)
                                                              : count_inc[CNT_BITS-1:0];

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      held_valid_in = held_valid_ff;
      held_time_in  = held_time_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      count_in      = count_ff;
      last_time_in  = last_time_ff;
      det_time_in   = det_time_ff;
      det_x_in      = det_x_ff;
      det_y_in      = det_y_ff;
      det_eos_in    = det_eos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_camera_in = rsp_camera_ff;
      rsp_last_in   = rsp_last_ff;
      blend_start   = 1'b0;
      blend_old     = '0;
      blend_neu     = '0;
      blend_count   = count_ff;

      // Drop the output beat once taken; a load below may refill it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               det_time_in = time_sat;
               det_x_in    = req_tdata[X_LSB +: COORD_BITS];
               det_y_in    = req_tdata[Y_LSB +: COORD_BITS];
               det_eos_in  = req_tlast;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!held_valid_ff) begin
               // Start a fresh cluster.
               held_time_in  = det_time_ff;
               held_x_in     = det_x_ff;
               held_y_in     = det_y_ff;
               count_in      = CNT_BITS'(1);
               held_valid_in = 1'b1;
               state_in      = ST_FLUSH_CHECK;
            end else begin
               // Replace a held point that sits too close to the edge; keep the count.
               if (held_low) begin
                  held_time_in = det_time_ff;
                  held_x_in    = det_x_ff;
                  held_y_in    = det_y_ff;
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (in_window) begin
               if (near) begin
                  count_in    = count_sat;
                  blend_start = 1'b1;
                  blend_old   = held_time_ff;
                  blend_neu   = det_time_ff;
                  blend_count = count_sat;
                  state_in    = ST_BLEND_TIME;
               end else begin
                  state_in = ST_FLUSH_CHECK;
               end
            end else begin
               state_in = ST_EMIT_OLD;
            end
         end
         ST_EMIT_OLD: begin
            // Emit the held cluster, then start a new one from the detection.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_time_in   = held_time_ff;
               rsp_x_in      = held_x_ff;
               rsp_y_in      = held_y_ff;
               rsp_camera_in = camera_id_ff;
               rsp_last_in   = !(det_eos_ff && (det_time_ff != held_time_ff));
               last_time_in  = held_time_ff;
               held_time_in  = det_time_ff;
               held_x_in     = det_x_ff;
               held_y_in     = det_y_ff;
               count_in      = CNT_BITS'(1);
               state_in      = ST_FLUSH_CHECK;
            end
         end
         ST_BLEND_TIME: begin
            if (blend_done) begin
               held_time_in = blend_result;
               blend_start  = 1'b1;
               blend_old    = TIME_BITS'(held_x_ff);
               blend_neu    = TIME_BITS'(det_x_ff);
               state_in     = ST_BLEND_X;
            end
         end
         ST_BLEND_X: begin
            if (blend_done) begin
               held_x_in   = blend_result[COORD_BITS-1:0];
               blend_start = 1'b1;
               blend_old   = TIME_BITS'(held_y_ff);
               blend_neu   = TIME_BITS'(det_y_ff);
               state_in    = ST_BLEND_Y;
            end
         end
         ST_BLEND_Y: begin
            if (blend_done) begin
               held_y_in = blend_result[COORD_BITS-1:0];
               state_in  = ST_FLUSH_CHECK;
            end
         end
         ST_FLUSH_CHECK: begin
            if (det_eos_ff) begin
               if (held_time_ff != last_time_ff) begin
                  state_in = ST_EMIT_FLUSH;
               end else begin
                  held_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_FLUSH: begin
            // Flush the held cluster at the end of the stream.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_time_in   = held_time_ff;
               rsp_x_in      = held_x_ff;
               rsp_y_in      = held_y_ff;
               rsp_camera_in = camera_id_ff;
               rsp_last_in   = 1'b1;
               last_time_in  = held_time_ff;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   tecavg_blend #(
      .VAL_BITS (TIME_BITS),
      .CNT_BITS (CNT_BITS)
   ) u_blend (
      .clock   (clock),
      .reset   (reset),
      .start   (blend_start),
      .old_val (blend_old),
      .neu_val (blend_neu),
      .count   (blend_count),
      .done    (blend_done),
      .result  (blend_result)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_window_ff    <= TIME_WINDOW_RESET;
         distance_limit_ff <= DISTANCE_LIMIT_RESET;
         min_valid_ff      <= MIN_VALID_COORD_RESET;
         camera_id_ff      <= CAMERA_ID_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TIME_WINDOW:     time_window_ff    <= csr_wdata[WINDOW_BITS-1:0];
            CSR_DISTANCE_LIMIT:  distance_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            CSR_MIN_VALID_COORD: min_valid_ff      <= csr_wdata[LIMIT_BITS-1:0];
            CSR_CAMERA_ID:       camera_id_ff      <= csr_wdata[CAMERA_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         last_time_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         last_time_ff  <= last_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      held_time_ff  <= held_time_in;
      held_x_ff     <= held_x_in;
      held_y_ff     <= held_y_in;
      det_time_ff   <= det_time_in;
      det_x_ff      <= det_x_in;
      det_y_ff      <= det_y_in;
      det_eos_ff    <= det_eos_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_camera_ff <= rsp_camera_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_camera_ff, rsp_y_ff, rsp_x_ff, rsp_time_ff});

endmodule
